// File: hw/rtl/paged_kv_page_table_manager_unit_assert.svh
// Assertion macros used by the page table manager datapath.
// No dependencies; the bodies are empty when SYNTH is defined.
`ifndef PAGED_KV_PAGE_TABLE_MANAGER_UNIT_ASSERT_SVH
`define PAGED_KV_PAGE_TABLE_MANAGER_UNIT_ASSERT_SVH
`ifndef SYNTH
`define PKVPT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("pkvpt: same-cycle check failed");
`define PKVPT_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("pkvpt: next-cycle check failed");
`else
`define PKVPT_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define PKVPT_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: hw/rtl/pkvpt_pkg.sv
// Package for the paged KV page table manager: widths, codes and the
// command/status structs between controller and datapath. No dependencies.
package pkvpt_pkg;

    localparam int POOL_PAGES      = 64;
    localparam int MAX_LAYERS      = 32;
    localparam int MAX_PAGE_TOKENS = 256;

    localparam int PAGE_W  = 6;
    localparam int LAYER_W = 5;
    localparam int NL_W    = 6;
    localparam int PS_W    = 9;
    localparam int SLOT_W  = 8;
    localparam int CNT_W   = 15;
    localparam int FC_W    = 7;
    localparam int NB_W    = 7;
    localparam int PT_AW   = LAYER_W + PAGE_W;
    localparam int DIV_W   = 16;
    localparam int ST_W    = 2;
    localparam int OP_W    = 2;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 40;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = PS_W;

    localparam logic [CNT_W-1:0] COUNT_MAX = 15'h7FFF;

    localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OP_W-1:0] OP_GATHER = 2'd1;
    localparam logic [OP_W-1:0] OP_TRUNC  = 2'd2;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_NO_PAGE   = 2'd1;
    localparam logic [ST_W-1:0] ST_BAD_LAYER = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SIZE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAYER_COUNT = 1'b1;

    typedef struct packed {
        logic            load_item;
        logic            div_tc;
        logic            div_tr;
        logic            take_tc;
        logic            take_tr;
        logic            app_rd;
        logic            app_commit;
        logic            gat_init;
        logic            gat_rd;
        logic            gat_emit;
        logic            tr_rd;
        logic            tr_push;
        logic            tr_next;
        logic            tr_finish;
        logic            emit_simple;
        logic [ST_W-1:0] emit_code;
    } cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            bad_layer;
        logic            rem_valid;
        logic            app_err;
        logic            gat_empty;
        logic            gat_last;
        logic            tr_noop;
        logic            tr_at_end;
        logic            tr_more;
        logic            div_done;
        logic            can_load;
    } sts_t;

endpackage

// File: hw/rtl/pkvpt_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on pkvpt_pkg.
module pkvpt_div
    import pkvpt_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DIV_W-1:0]  dividend,
    input  logic [PS_W-1:0]   divisor,
    output logic              done,
    output logic [DIV_W-1:0]  quotient,
    output logic [PS_W-1:0]   remainder
);

    localparam int CW = $clog2(DIV_W);

    logic            busy_reg;
    logic            done_reg;
    logic [CW-1:0]   cnt_reg;
    logic [DIV_W-1:0] quo_reg;
    logic [PS_W-1:0] rem_reg;
    logic [PS_W-1:0] dvs_reg;
    logic [PS_W:0]   shifted;
    logic [PS_W:0]   diff;
    logic            ge;

    assign shifted = {rem_reg, quo_reg[DIV_W-1]};
    assign ge      = shifted >= {1'b0, dvs_reg};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            if (start) begin
                busy_reg <= 1'b1;
                done_reg <= 1'b0;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg  <= cnt_reg + CW'(1);
                busy_reg <= (cnt_reg != CW'(DIV_W - 1));
                done_reg <= (cnt_reg == CW'(DIV_W - 1));
            end else begin
                done_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DIV_W-2:0], ge};
            rem_reg <= ge ? diff[PS_W-1:0] : shifted[PS_W-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// File: hw/rtl/pkvpt_ctrl.sv
// Controller state machine: sequences append, gather and truncate.
// Depends on pkvpt_pkg; drives the datapath through cmd_t, reads sts_t.
module pkvpt_ctrl
    import pkvpt_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_EMIT, S_DIV_TC, S_APP_CHK, S_APP_WB,
        S_GAT_RD, S_GAT_EM, S_DIV_TR, S_TR_SCAN, S_TR_PUSH, S_TR_FIN
    } state_t;

    state_t          state_reg, state_next;
    logic [ST_W-1:0] code_reg, code_next;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        code_next  = code_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (sts.op)
                    OP_APPEND: begin
                        if (sts.bad_layer) begin
                            code_next  = ST_BAD_LAYER;
                            state_next = S_EMIT;
                        end else if (!sts.rem_valid) begin
                            cmd.div_tc = 1'b1;
                            state_next = S_DIV_TC;
                        end else begin
                            state_next = S_APP_CHK;
                        end
                    end
                    OP_GATHER: begin
                        if (sts.bad_layer) begin
                            code_next  = ST_BAD_LAYER;
                            state_next = S_EMIT;
                        end else if (sts.gat_empty) begin
                            code_next  = ST_OK;
                            state_next = S_EMIT;
                        end else begin
                            cmd.gat_init = 1'b1;
                            state_next   = S_GAT_RD;
                        end
                    end
                    OP_TRUNC: begin
                        if (sts.tr_noop) begin
                            code_next  = ST_OK;
                            state_next = S_EMIT;
                        end else begin
                            cmd.div_tr = 1'b1;
                            state_next = S_DIV_TR;
                        end
                    end
                    default: begin
                        code_next  = ST_OK;
                        state_next = S_EMIT;
                    end
                endcase
            end
            S_EMIT: begin
                if (sts.can_load) begin
                    cmd.emit_simple = 1'b1;
                    cmd.emit_code   = code_reg;
                    state_next      = S_IDLE;
                end
            end
            S_DIV_TC: begin
                if (sts.div_done) begin
                    cmd.take_tc = 1'b1;
                    state_next  = S_APP_CHK;
                end
            end
            S_APP_CHK: begin
                if (sts.app_err) begin
                    code_next  = ST_NO_PAGE;
                    state_next = S_EMIT;
                end else begin
                    cmd.app_rd = 1'b1;
                    state_next = S_APP_WB;
                end
            end
            S_APP_WB: begin
                if (sts.can_load) begin
                    cmd.app_commit = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_GAT_RD: begin
                cmd.gat_rd = 1'b1;
                state_next = S_GAT_EM;
            end
            S_GAT_EM: begin
                if (sts.can_load) begin
                    cmd.gat_emit = 1'b1;
                    state_next   = sts.gat_last ? S_IDLE : S_GAT_RD;
                end
            end
            S_DIV_TR: begin
                if (sts.div_done) begin
                    cmd.take_tr = 1'b1;
                    state_next  = S_TR_SCAN;
                end
            end
            S_TR_SCAN: begin
                priority if (sts.tr_at_end) begin
                    state_next = S_TR_FIN;
                end else if (sts.tr_more) begin
                    cmd.tr_rd  = 1'b1;
                    state_next = S_TR_PUSH;
                end else begin
                    cmd.tr_next = 1'b1;
                end
            end
            S_TR_PUSH: begin
                cmd.tr_push = 1'b1;
                state_next  = S_TR_SCAN;
            end
            S_TR_FIN: begin
                if (sts.can_load) begin
                    cmd.tr_finish = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            code_reg  <= ST_OK;
        end else begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

endmodule

// File: hw/rtl/pkvpt_dp.sv
// Datapath: free page stack, page table memory, block counts, token
// count, divider and output register. Depends on pkvpt_pkg, pkvpt_div.
`include "paged_kv_page_table_manager_unit_assert.svh"
module pkvpt_dp
    import pkvpt_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic [OP_W-1:0]        s_tuser,
    input  cmd_t                   cmd,
    output sts_t                   sts,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic [ST_W-1:0]        m_tuser,
    output logic                   m_tlast
);

    logic [PS_W-1:0]    ps_reg;
    logic [NL_W-1:0]    nl_reg;
    logic [PS_W-1:0]    ps_eff;
    logic [NL_W-1:0]    nl_eff;
    logic [CNT_W-1:0]   tc_reg;
    logic [SLOT_W-1:0]  rem_reg;
    logic               rem_valid_reg;
    logic [FC_W-1:0]    fc_reg;
    logic [NB_W-1:0]    bpl_reg [MAX_LAYERS];
    logic [POOL_PAGES-1:0] fs_valid_reg;

    logic [OP_W-1:0]    op_reg;
    logic [LAYER_W-1:0] layer_reg;
    logic [CNT_W-1:0]   len_reg;
    logic [NB_W-1:0]    keep_reg;
    logic [NL_W-1:0]    l_reg;
    logic [NB_W-1:0]    b_reg;
    logic [CNT_W-1:0]   left_reg;

    logic [PAGE_W-1:0]  fs_mem [POOL_PAGES];
    logic [PAGE_W-1:0]  fs_rd_data_reg;
    logic [PAGE_W-1:0]  fs_rd_addr_reg;
    logic               fs_rd_valid_reg;
    logic [PAGE_W-1:0]  pt_mem [1 << PT_AW];
    logic [PAGE_W-1:0]  pt_rd_reg;

    logic               m_tvalid_reg;
    logic [ST_W-1:0]    out_status_reg, out_status_next;
    logic [PAGE_W-1:0]  out_page_reg, out_page_next;
    logic [SLOT_W-1:0]  out_slot_reg, out_slot_next;
    logic [PS_W-1:0]    out_tok_reg, out_tok_next;
    logic [CNT_W-1:0]   out_cached_reg, out_cached_next;
    logic               out_last_reg, out_last_next;

    logic [NB_W-1:0]    nb_sel;
    logic [NB_W-1:0]    nb_tr;
    logic [NB_W-1:0]    nb_m1;
    logic [PS_W-1:0]    ps_m1;
    logic [SLOT_W-1:0]  app_slot;
    logic               app_need;
    logic               app_err;
    logic [PAGE_W-1:0]  pg_new;
    logic [PAGE_W-1:0]  app_pg;
    logic [PS_W-1:0]    rem_inc;
    logic [SLOT_W-1:0]  rem_after_app;
    logic [PS_W-1:0]    div_r_inc;
    logic [SLOT_W-1:0]  rem_after_tr;
    logic [NB_W-1:0]    keep_clip;
    logic [PS_W-1:0]    gat_cnt;
    logic               can_load;
    logic               out_load;
    logic               fs_we;
    logic [PAGE_W-1:0]  fs_ra;
    logic               pt_we;
    logic [PT_AW-1:0]   pt_wa;
    logic               pt_re;
    logic [PT_AW-1:0]   pt_ra;

    logic               div_start;
    logic [DIV_W-1:0]   div_dividend;
    logic               div_done;
    logic [DIV_W-1:0]   div_q;
    logic [PS_W-1:0]    div_r;

    always_comb begin
        priority if (ps_reg == '0) ps_eff = PS_W'(1);
        else if (ps_reg > PS_W'(MAX_PAGE_TOKENS)) ps_eff = PS_W'(MAX_PAGE_TOKENS);
        else ps_eff = ps_reg;
        priority if (nl_reg == '0) nl_eff = NL_W'(1);
        else if (nl_reg > NL_W'(MAX_LAYERS)) nl_eff = NL_W'(MAX_LAYERS);
        else nl_eff = nl_reg;
    end

    assign nb_sel = bpl_reg[layer_reg];
    assign nb_tr  = bpl_reg[l_reg[LAYER_W-1:0]];
    assign nb_m1  = nb_sel - NB_W'(1);
    assign ps_m1  = ps_eff - PS_W'(1);

    always_comb begin
        if (layer_reg == '0) begin
            app_slot = rem_reg;
        end else if (rem_reg == '0) begin
            app_slot = ps_m1[SLOT_W-1:0];
        end else begin
            app_slot = rem_reg - SLOT_W'(1);
        end
        app_need = (app_slot == '0);
        app_err  = (layer_reg == '0) ? (tc_reg == COUNT_MAX) : (tc_reg == '0);
        if (app_need) begin
            app_err = app_err || (fc_reg == '0) || (nb_sel >= NB_W'(POOL_PAGES));
        end else begin
            app_err = app_err || (nb_sel == '0);
        end
    end

    assign pg_new        = fs_rd_valid_reg ? fs_rd_data_reg : fs_rd_addr_reg;
    assign app_pg        = app_need ? pg_new : pt_rd_reg;
    assign rem_inc       = PS_W'(rem_reg) + PS_W'(1);
    assign rem_after_app = (rem_inc == ps_eff) ? '0 : rem_inc[SLOT_W-1:0];
    assign div_r_inc     = div_r + PS_W'(1);
    assign rem_after_tr  = (div_r_inc == ps_eff) ? '0 : div_r_inc[SLOT_W-1:0];
    assign keep_clip     = (div_q > DIV_W'(POOL_PAGES)) ? NB_W'(POOL_PAGES)
                                                        : div_q[NB_W-1:0];
    assign gat_cnt       = (left_reg < CNT_W'(ps_eff)) ? left_reg[PS_W-1:0] : ps_eff;

    assign can_load = !m_tvalid_reg || m_tready;
    assign out_load = cmd.emit_simple || cmd.app_commit || cmd.gat_emit || cmd.tr_finish;

    assign div_start    = cmd.div_tc || cmd.div_tr;
    assign div_dividend = cmd.div_tc ? DIV_W'(tc_reg)
                                     : DIV_W'(len_reg) + DIV_W'(ps_eff) - DIV_W'(1);

    pkvpt_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (ps_eff),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // Page table port mux
    always_comb begin
        pt_re = cmd.app_rd || cmd.gat_rd || cmd.tr_rd;
        priority if (cmd.app_rd) pt_ra = {layer_reg, nb_m1[PAGE_W-1:0]};
        else if (cmd.gat_rd) pt_ra = {layer_reg, b_reg[PAGE_W-1:0]};
        else pt_ra = {l_reg[LAYER_W-1:0], b_reg[PAGE_W-1:0]};
        pt_we = cmd.app_commit && app_need;
        pt_wa = {layer_reg, nb_sel[PAGE_W-1:0]};
    end

    assign fs_we = cmd.tr_push && (fc_reg < FC_W'(POOL_PAGES));
    assign fs_ra = fc_reg[PAGE_W-1:0] - PAGE_W'(1);

    always_ff @(posedge aclk) begin
        if (pt_we) begin
            pt_mem[pt_wa] <= app_pg;
        end
        if (pt_re) begin
            pt_rd_reg <= pt_mem[pt_ra];
        end
    end

    always_ff @(posedge aclk) begin
        if (fs_we) begin
            fs_mem[fc_reg[PAGE_W-1:0]] <= pt_rd_reg;
        end
        if (cmd.app_rd) begin
            fs_rd_data_reg  <= fs_mem[fs_ra];
            fs_rd_addr_reg  <= fs_ra;
            fs_rd_valid_reg <= fs_valid_reg[fs_ra];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ps_reg        <= PS_W'(16);
            nl_reg        <= NL_W'(1);
            tc_reg        <= '0;
            rem_reg       <= '0;
            rem_valid_reg <= 1'b1;
            fc_reg        <= FC_W'(POOL_PAGES);
            fs_valid_reg  <= '0;
            m_tvalid_reg  <= 1'b0;
            for (int i = 0; i < MAX_LAYERS; i++) begin
                bpl_reg[i] <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_PAGE_SIZE: begin
                        ps_reg        <= cfg_wdata;
                        rem_valid_reg <= 1'b0;
                    end
                    CFG_LAYER_COUNT: nl_reg <= cfg_wdata[NL_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.take_tc) begin
                rem_reg       <= div_r[SLOT_W-1:0];
                rem_valid_reg <= 1'b1;
            end
            if (cmd.take_tr) begin
                rem_reg       <= rem_after_tr;
                rem_valid_reg <= 1'b1;
            end
            if (cmd.app_commit) begin
                if (app_need) begin
                    fc_reg             <= fc_reg - FC_W'(1);
                    bpl_reg[layer_reg] <= nb_sel + NB_W'(1);
                end
                if (layer_reg == '0) begin
                    tc_reg  <= tc_reg + CNT_W'(1);
                    rem_reg <= rem_after_app;
                end
            end
            if (fs_we) begin
                fs_valid_reg[fc_reg[PAGE_W-1:0]] <= 1'b1;
                fc_reg                           <= fc_reg + FC_W'(1);
            end
            if (cmd.tr_next && (nb_tr > keep_reg)) begin
                bpl_reg[l_reg[LAYER_W-1:0]] <= keep_reg;
            end
            if (cmd.tr_finish) begin
                tc_reg <= len_reg;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            op_reg    <= s_tuser;
            layer_reg <= s_tdata[LAYER_W-1:0];
            len_reg   <= s_tdata[LAYER_W +: CNT_W];
        end
        if (cmd.take_tr) begin
            keep_reg <= keep_clip;
            l_reg    <= '0;
            b_reg    <= keep_clip;
        end
        if (cmd.gat_init) begin
            b_reg    <= '0;
            left_reg <= tc_reg;
        end
        if (cmd.gat_emit) begin
            b_reg    <= b_reg + NB_W'(1);
            left_reg <= left_reg - CNT_W'(gat_cnt);
        end
        if (cmd.tr_push) begin
            b_reg <= b_reg + NB_W'(1);
        end
        if (cmd.tr_next) begin
            l_reg <= l_reg + NL_W'(1);
            b_reg <= keep_reg;
        end
    end

    always_comb begin
        out_status_next = ST_OK;
        out_page_next   = '0;
        out_slot_next   = '0;
        out_tok_next    = '0;
        out_cached_next = tc_reg;
        out_last_next   = 1'b1;
        priority if (cmd.emit_simple) begin
            out_status_next = cmd.emit_code;
        end else if (cmd.app_commit) begin
            out_page_next   = app_pg;
            out_slot_next   = app_slot;
            out_cached_next = (layer_reg == '0) ? tc_reg + CNT_W'(1) : tc_reg;
        end else if (cmd.gat_emit) begin
            out_page_next = pt_rd_reg;
            out_tok_next  = gat_cnt;
            out_last_next = (b_reg + NB_W'(1) == nb_sel);
        end else begin
            out_cached_next = len_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_status_reg <= out_status_next;
            out_page_reg   <= out_page_next;
            out_slot_reg   <= out_slot_next;
            out_tok_reg    <= out_tok_next;
            out_cached_reg <= out_cached_next;
            out_last_reg   <= out_last_next;
        end
    end

    always_comb begin
        sts.op        = op_reg;
        sts.bad_layer = NL_W'(layer_reg) >= nl_eff;
        sts.rem_valid = rem_valid_reg;
        sts.app_err   = app_err;
        sts.gat_empty = (tc_reg == '0) || (nb_sel == '0);
        sts.gat_last  = (b_reg + NB_W'(1) == nb_sel);
        sts.tr_noop   = len_reg >= tc_reg;
        sts.tr_at_end = l_reg == nl_eff;
        sts.tr_more   = b_reg < nb_tr;
        sts.div_done  = div_done;
        sts.can_load  = can_load;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = OUT_TDATA_W'({out_cached_reg, out_tok_reg, out_slot_reg, out_page_reg});

    `PKVPT_ASSERT_IMP(a_fc_range, aclk, aresetn, 1'b1, fc_reg <= FC_W'(POOL_PAGES))
    `PKVPT_ASSERT_IMP(a_pop_nonempty, aclk, aresetn, cmd.app_commit && app_need, fc_reg != '0)
    `PKVPT_ASSERT_IMP(a_load_free, aclk, aresetn, out_load, can_load)
    `PKVPT_ASSERT_IMP(a_rem_range, aclk, aresetn, rem_valid_reg, PS_W'(rem_reg) < ps_eff)
    `PKVPT_ASSERT_NXT(a_div_held, aclk, aresetn, div_start, !div_done)

endmodule

// File: hw/rtl/paged_kv_page_table_manager_unit.sv
// Paged KV cache page table manager: one item at a time through a single
// output register. An append, accepted or refused, passes through dispatch
// and a check before its result beat, with a run of the remainder divider
// first on the first append after the page size is written. A gather does
// one page table memory read, then the beat, per listed page. A shortening
// truncate runs the divider, then scans each layer in use and pushes pages
// back one by one. Bad-layer, empty and other trivial items go from dispatch
// straight to a status beat. A result beat held back by m_tready stalls it.
module paged_kv_page_table_manager_unit
    import pkvpt_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // layer[4:0], new_length[19:5], zero
    input  logic [OP_W-1:0]        s_tuser,   // op[1:0]
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // page_id, slot_in_page, tokens_in_page,
                                              // cached_tokens, zero
    output logic [ST_W-1:0]        m_tuser,   // status[1:0]
    output logic                   m_tlast,
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    cmd_t cmd;
    sts_t sts;

    pkvpt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pkvpt_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
